@@ sv/tsfg_pkg.sv @@
// Package for the TCP SYN frame generator: payload types, codes and header constants.
package tsfg_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_IP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MAC = 2'd1;
  localparam int unsigned CFG_DATA_W = 48;

  // Frame geometry
  localparam int unsigned FRAME_LEN = 54;
  localparam int unsigned BYTE_IDX_W = $clog2(FRAME_LEN);
  localparam logic [BYTE_IDX_W-1:0] LAST_IDX = BYTE_IDX_W'(FRAME_LEN - 1);

  // Fixed header bytes
  localparam logic [7:0] ETH_TYPE_HI = 8'h08;
  localparam logic [7:0] ETH_TYPE_LO = 8'h00;
  localparam logic [7:0] IP_VER_IHL  = 8'h45;
  localparam logic [7:0] IP_LEN_LO   = 8'h28;
  localparam logic [7:0] IP_TTL      = 8'hff;
  localparam logic [7:0] IP_PROTO    = 8'h06;
  localparam logic [7:0] TCP_DOFF    = 8'h50;
  localparam logic [7:0] TCP_FLAGS   = 8'h02;
  localparam logic [7:0] TCP_WIN     = 8'hff;

  // Sum of the constant words: 0x4500 + 0x0028 + 0xff06
  localparam logic [17:0] IP_CONST_SUM  = 18'h1442e;
  // Pseudo-header proto + length (0x1a) plus 0x5002 + 0xffff
  localparam logic [19:0] TCP_CONST_SUM = 20'h1501b;

  typedef struct packed {
    logic [31:0] dest_ip;
    logic [47:0] dest_mac;
    logic [15:0] dest_port;
    logic [15:0] ip_ident;
    logic [15:0] tcp_src_port;
    logic [31:0] seq_number;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } out_beat_t;

  // Request plus both finished checksums, handed to the serializer
  typedef struct packed {
    in_beat_t    req;
    logic [15:0] ip_cksum;
    logic [15:0] tcp_cksum;
  } frame_t;

endpackage

@@ sv/tsfg_cksum_pipe.sv @@
// Four-stage checksum pipeline: partial sums, total, first fold, final fold and invert.
module tsfg_cksum_pipe
  import tsfg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] source_ip,
  input  logic        up_valid,
  output logic        up_ready,
  input  in_beat_t    up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output frame_t      dn_data
);

  logic        s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic        s1_adv, s2_adv, s3_adv, s4_adv;
  in_beat_t    s1_req_r, s2_req_r, s3_req_r;
  logic [17:0] s1_ip_a_r, s1_ip_b_r, s1_tcp_a_r, s1_tcp_b_r;
  logic [18:0] s2_ip_r;
  logic [19:0] s2_tcp_r;
  logic [16:0] s3_ip_r, s3_tcp_r;
  frame_t      s4_r;

  // Stage handshake: a stage loads when it is empty or its content moves on
  assign s4_adv   = !s4_v_r || dn_ready;
  assign s3_adv   = !s3_v_r || s4_adv;
  assign s2_adv   = !s2_v_r || s3_adv;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign up_ready = s1_adv;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (s1_adv) s1_v_r <= up_valid;
      if (s2_adv) s2_v_r <= s1_v_r;
      if (s3_adv) s3_v_r <= s2_v_r;
      if (s4_adv) s4_v_r <= s3_v_r;
    end
  end

  // Stage 1: pairwise partial sums of the header words
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_req_r   <= up_data;
      s1_ip_a_r  <= {2'b0, up_data.ip_ident} + {2'b0, source_ip[31:16]}
                    + {2'b0, source_ip[15:0]};
      s1_ip_b_r  <= {2'b0, up_data.dest_ip[31:16]} + {2'b0, up_data.dest_ip[15:0]}
                    + IP_CONST_SUM;
      s1_tcp_a_r <= {2'b0, source_ip[31:16]} + {2'b0, source_ip[15:0]}
                    + {2'b0, up_data.dest_ip[31:16]} + {2'b0, up_data.dest_ip[15:0]};
      s1_tcp_b_r <= {2'b0, up_data.tcp_src_port} + {2'b0, up_data.dest_port}
                    + {2'b0, up_data.seq_number[31:16]}
                    + {2'b0, up_data.seq_number[15:0]};
    end
  end

  // Stage 2: full sums
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_req_r <= s1_req_r;
      s2_ip_r  <= {1'b0, s1_ip_a_r} + {1'b0, s1_ip_b_r};
      s2_tcp_r <= {2'b0, s1_tcp_a_r} + {2'b0, s1_tcp_b_r} + TCP_CONST_SUM;
    end
  end

  // Stage 3: first end-around carry fold
  always_ff @(posedge clk) begin
    if (s3_adv) begin
      s3_req_r <= s2_req_r;
      s3_ip_r  <= {1'b0, s2_ip_r[15:0]} + {14'b0, s2_ip_r[18:16]};
      s3_tcp_r <= {1'b0, s2_tcp_r[15:0]} + {13'b0, s2_tcp_r[19:16]};
    end
  end

  // Stage 4: second fold, which cannot carry again, then invert
  always_ff @(posedge clk) begin
    if (s4_adv) begin
      s4_r.req       <= s3_req_r;
      s4_r.ip_cksum  <= ~(s3_ip_r[15:0] + {15'b0, s3_ip_r[16]});
      s4_r.tcp_cksum <= ~(s3_tcp_r[15:0] + {15'b0, s3_tcp_r[16]});
    end
  end

  assign dn_valid = s4_v_r;
  assign dn_data  = s4_r;

endmodule

@@ sv/tsfg_serializer.sv @@
// Frame serializer: holds one finished header set and sends it a byte per beat.
module tsfg_serializer
  import tsfg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] source_ip,
  input  logic [47:0] source_mac,
  input  logic        up_valid,
  output logic        up_ready,
  input  frame_t      up_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data
);

  logic                  busy_r;
  logic [BYTE_IDX_W-1:0] cnt_r, cnt_nxt;
  frame_t                frame_r;
  logic                  out_valid_r;
  out_beat_t             out_data_r;
  logic                  out_free, emit, at_last, load;
  logic [7:0]            byte_sel;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = busy_r && out_free;
  assign at_last  = (cnt_r == LAST_IDX);
  assign up_ready = !busy_r || (emit && at_last);
  assign load     = up_valid && up_ready;
  assign cnt_nxt  = at_last ? '0 : cnt_r + 1'b1;

  // Byte at the current position, wire order
  always_comb begin
    byte_sel = 8'h00;
    case (cnt_r)
      6'd0:  byte_sel = frame_r.req.dest_mac[47:40];
      6'd1:  byte_sel = frame_r.req.dest_mac[39:32];
      6'd2:  byte_sel = frame_r.req.dest_mac[31:24];
      6'd3:  byte_sel = frame_r.req.dest_mac[23:16];
      6'd4:  byte_sel = frame_r.req.dest_mac[15:8];
      6'd5:  byte_sel = frame_r.req.dest_mac[7:0];
      6'd6:  byte_sel = source_mac[47:40];
      6'd7:  byte_sel = source_mac[39:32];
      6'd8:  byte_sel = source_mac[31:24];
      6'd9:  byte_sel = source_mac[23:16];
      6'd10: byte_sel = source_mac[15:8];
      6'd11: byte_sel = source_mac[7:0];
      6'd12: byte_sel = ETH_TYPE_HI;
      6'd13: byte_sel = ETH_TYPE_LO;
      6'd14: byte_sel = IP_VER_IHL;
      6'd17: byte_sel = IP_LEN_LO;
      6'd18: byte_sel = frame_r.req.ip_ident[15:8];
      6'd19: byte_sel = frame_r.req.ip_ident[7:0];
      6'd22: byte_sel = IP_TTL;
      6'd23: byte_sel = IP_PROTO;
      6'd24: byte_sel = frame_r.ip_cksum[15:8];
      6'd25: byte_sel = frame_r.ip_cksum[7:0];
      6'd26: byte_sel = source_ip[31:24];
      6'd27: byte_sel = source_ip[23:16];
      6'd28: byte_sel = source_ip[15:8];
      6'd29: byte_sel = source_ip[7:0];
      6'd30: byte_sel = frame_r.req.dest_ip[31:24];
      6'd31: byte_sel = frame_r.req.dest_ip[23:16];
      6'd32: byte_sel = frame_r.req.dest_ip[15:8];
      6'd33: byte_sel = frame_r.req.dest_ip[7:0];
      6'd34: byte_sel = frame_r.req.tcp_src_port[15:8];
      6'd35: byte_sel = frame_r.req.tcp_src_port[7:0];
      6'd36: byte_sel = frame_r.req.dest_port[15:8];
      6'd37: byte_sel = frame_r.req.dest_port[7:0];
      6'd38: byte_sel = frame_r.req.seq_number[31:24];
      6'd39: byte_sel = frame_r.req.seq_number[23:16];
      6'd40: byte_sel = frame_r.req.seq_number[15:8];
      6'd41: byte_sel = frame_r.req.seq_number[7:0];
      6'd46: byte_sel = TCP_DOFF;
      6'd47: byte_sel = TCP_FLAGS;
      6'd48: byte_sel = TCP_WIN;
      6'd49: byte_sel = TCP_WIN;
      6'd50: byte_sel = frame_r.tcp_cksum[15:8];
      6'd51: byte_sel = frame_r.tcp_cksum[7:0];
      default: byte_sel = 8'h00;
    endcase
  end

  // Position counter and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (emit) begin
      busy_r <= !at_last;
      cnt_r  <= cnt_nxt;
    end
  end

  // Held header set
  always_ff @(posedge clk) begin
    if (load) frame_r <= up_data;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.frame_byte <= byte_sel;
      out_data_r.last_byte  <= at_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A frame always starts at the first byte
  a_load_starts_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (busy_r && cnt_r == '0))
    else $error("serializer loaded without restarting count");

  // The last byte leaves the block idle unless a new frame was loaded
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && at_last && !load) |=> !busy_r)
    else $error("serializer still busy after last byte");

  // No new frame is taken mid-frame
  a_no_load_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !at_last) |-> !load)
    else $error("frame loaded over one in progress");

endmodule

@@ sv/tcp_syn_frame_generator.sv @@
// Top level of the TCP SYN frame generator: configuration registers, pipeline, serializer.
// Each accepted request becomes one 54-byte Ethernet/IPv4/TCP SYN frame on out_data, one byte
// per beat in wire order, with last_byte set on byte 54. Checksums are computed in a four-stage
// pipeline. The serializer sends one byte per cycle while out_stall is low, and takes the next
// request only as the last byte of the current frame is sent; up to four further requests queue
// in the pipeline while a frame is being sent, and in_stall rises once it is full. source_ip
// (index 0) and source_mac (index 1) are written through the cfg port, which is always ready;
// writes to other indexes are ignored. Change them only while the block is idle.
module tcp_syn_frame_generator
  import tsfg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [31:0] source_ip_r;
  logic [47:0] source_mac_r;
  logic        pipe_ready, pipe_dn_valid, ser_ready;
  frame_t      pipe_dn_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = !pipe_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_ip_r  <= '0;
      source_mac_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SOURCE_IP:  source_ip_r  <= cfg_data[31:0];
        CFG_SOURCE_MAC: source_mac_r <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  tsfg_cksum_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .source_ip (source_ip_r),
    .up_valid  (in_valid),
    .up_ready  (pipe_ready),
    .up_data   (in_data),
    .dn_valid  (pipe_dn_valid),
    .dn_ready  (ser_ready),
    .dn_data   (pipe_dn_data)
  );

  tsfg_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .source_ip  (source_ip_r),
    .source_mac (source_mac_r),
    .up_valid   (pipe_dn_valid),
    .up_ready   (ser_ready),
    .up_data    (pipe_dn_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
